// ----- sv/cau_pkg.sv -----
// Shared types, widths and helper functions of the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

	localparam int DW   = 16;          // operand and result width
	localparam int FB   = 8;           // fractional bits
	localparam int PW   = 2 * DW;      // signed product width
	localparam int SW   = PW + 1;      // width of a sum of two products
	localparam int MW   = PW;          // magnitude of a divide numerator
	localparam int XW   = MW + FB;     // dividend after the fraction shift
	localparam int QW   = DW + 1;      // quotient bits kept by the divider
	localparam int DENW = PW;          // divisor c*c + d*d
	localparam int CW   = DENW + QW;   // compare width of a divide step

	localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (DW - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
	localparam logic [QW-1:0] Q_HALF = QW'(1) << (DW - 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic sat;
		logic signed [DW-1:0] val;
	} sat_t;

	typedef struct packed {
		logic [XW-1:0] rem;
		logic [QW-1:0] quo;
		logic neg;
		logic ovf;
	} dlane_t;

	typedef struct packed {
		logic is_div;
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic sat;
		logic dz;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		logic [DENW-1:0] den;
		dlane_t re;
		dlane_t im;
	} dstg_t;

	// Clip a wide signed value to the result range.
	function automatic sat_t sat_fn(input logic signed [SW-1:0] v);
		sat_t r;
		r.sat = 1'b0;
		r.val = v[DW-1:0];
		if (v > SAT_HI) begin
			r.sat = 1'b1;
			r.val = SAT_HI[DW-1:0];
		end else if (v < SAT_LO) begin
			r.sat = 1'b1;
			r.val = SAT_LO[DW-1:0];
		end
		return r;
	endfunction

	// One restoring divide step against the already shifted divisor.
	function automatic dlane_t div_step(input dlane_t x, input logic [CW-1:0] dsh,
			input logic [QW-1:0] bitm);
		dlane_t y;
		logic [CW-1:0] r;
		logic [CW-1:0] diff;
		y = x;
		r = CW'(x.rem);
		diff = r - dsh;
		if (r >= dsh) begin
			y.rem = diff[XW-1:0];
			y.quo = x.quo | bitm;
		end
		return y;
	endfunction

	// Apply the sign to a quotient magnitude and clip it.
	function automatic sat_t div_fin(input dlane_t x);
		sat_t r;
		logic [QW-1:0] nq;
		nq = QW'(0) - x.quo;
		r.sat = 1'b0;
		r.val = x.quo[DW-1:0];
		if (x.neg) begin
			if (x.ovf || x.quo > Q_HALF) begin
				r.sat = 1'b1;
				r.val = SAT_LO[DW-1:0];
			end else begin
				r.val = nq[DW-1:0];
			end
		end else if (x.ovf || x.quo > (Q_HALF - QW'(1))) begin
			r.sat = 1'b1;
			r.val = SAT_HI[DW-1:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/cau_req_if.sv -----
// Request channel of the complex arithmetic unit.
`timescale 1ns / 1ps

interface cau_req_if
	import cau_pkg::*;
	;
	logic valid;
	logic ready;
	op_t kind;
	logic signed [DW-1:0] a_real;
	logic signed [DW-1:0] a_imag;
	logic signed [DW-1:0] b_real;
	logic signed [DW-1:0] b_imag;

	modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ----- sv/cau_rsp_if.sv -----
// Result channel of the complex arithmetic unit.
`timescale 1ns / 1ps

interface cau_rsp_if
	import cau_pkg::*;
	;
	logic valid;
	logic ready;
	logic signed [DW-1:0] res_real;
	logic signed [DW-1:0] res_imag;
	logic saturated;
	logic divide_by_zero;

	modport source (output valid, res_real, res_imag, saturated, divide_by_zero,
		input ready);
	modport sink (input valid, res_real, res_imag, saturated, divide_by_zero,
		output ready);
endinterface

// ----- sv/complex_arithmetic_unit_top.sv -----
// Pipeline: 3 arithmetic stages, 17 restoring divide stages and 1 output register lie
// between an accepted request and its result, the same for every operation.
// Throughput: one request per cycle; each stage holds while the stage after it is full
// and stalled, and a bubble anywhere is filled by the stage before it.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
`timescale 1ns / 1ps

module complex_arithmetic_unit_top
	import cau_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cau_req_if.sink req,
	cau_rsp_if.source rsp
);

	// Stage 1 holds the six 16x16 products and the finished add or subtract.
	// Stage 2 forms the two multiply sums, the two divide numerator sums and the divisor c*c + d*d.
	// Stage 3 finishes multiply results and sets up the two divide lanes, which
	// then walk through one quotient bit per stage, top bit first. The first
	// divide stage also flags quotients too large for the kept bits.

	// Per-stage load enables: a stage may load when it is empty or when the
	// stage after it moves on in the same cycle.
	logic en_s1, en_s2, en_s3, en_out;
	logic en_d [QW];

	logic v_s1, v_s2, v_s3, v_out_q;
	logic dv_sd [QW];
	dstg_t dstg_sd [QW];

	// Stage 1 registers.
	op_t kind_s1;
	logic signed [PW-1:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	tag_t as_s1;

	// Stage 2 registers.
	op_t kind_s2;
	tag_t as_s2;
	logic signed [SW-1:0] mre_s2, mim_s2, dre_s2, dim_s2;
	logic [DENW-1:0] den_s2;

	// Stage 3 register.
	dstg_t st3_s3;

	// Output register.
	logic signed [DW-1:0] res_re_q, res_im_q;
	logic sat_q, dz_q;

	sat_t add_re, add_im;
	tag_t as_nxt;
	sat_t mul_re, mul_im;
	dstg_t st3_nxt;
	logic dre_neg, dim_neg;
	logic signed [SW-1:0] dre_mag, dim_mag;
	sat_t fin_re, fin_im;

	assign en_out = !v_out_q || rsp.ready;
	assign en_s3 = !v_s3 || en_d[0];
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// Add and subtract finish in the first stage.
	always_comb begin
		if (req.kind == OP_SUB) begin
			add_re = sat_fn(SW'(req.a_real) - SW'(req.b_real));
			add_im = sat_fn(SW'(req.a_imag) - SW'(req.b_imag));
		end else begin
			add_re = sat_fn(SW'(req.a_real) + SW'(req.b_real));
			add_im = sat_fn(SW'(req.a_imag) + SW'(req.b_imag));
		end
		as_nxt.is_div = 1'b0;
		as_nxt.re = add_re.val;
		as_nxt.im = add_im.val;
		as_nxt.sat = add_re.sat | add_im.sat;
		as_nxt.dz = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1 <= req.kind;
			as_s1 <= as_nxt;
			ac_s1 <= req.a_real * req.b_real;
			bd_s1 <= req.a_imag * req.b_imag;
			ad_s1 <= req.a_real * req.b_imag;
			bc_s1 <= req.a_imag * req.b_real;
			cc_s1 <= req.b_real * req.b_real;
			dd_s1 <= req.b_imag * req.b_imag;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2 <= kind_s1;
			as_s2 <= as_s1;
			mre_s2 <= SW'(ac_s1) - SW'(bd_s1);
			mim_s2 <= SW'(ad_s1) + SW'(bc_s1);
			dre_s2 <= SW'(ac_s1) + SW'(bd_s1);
			dim_s2 <= SW'(bc_s1) - SW'(ad_s1);
			den_s2 <= DENW'(cc_s1) + DENW'(dd_s1);
		end
	end

	// Stage 3: multiply rounds toward minus infinity, divide takes magnitudes.
	always_comb begin
		mul_re = sat_fn(mre_s2 >>> FB);
		mul_im = sat_fn(mim_s2 >>> FB);
		dre_neg = dre_s2[SW-1];
		dim_neg = dim_s2[SW-1];
		dre_mag = dre_neg ? -dre_s2 : dre_s2;
		dim_mag = dim_neg ? -dim_s2 : dim_s2;

		st3_nxt.den = den_s2;
		st3_nxt.re.rem = XW'(dre_mag[MW-1:0]) << FB;
		st3_nxt.re.quo = '0;
		st3_nxt.re.neg = dre_neg;
		st3_nxt.re.ovf = 1'b0;
		st3_nxt.im.rem = XW'(dim_mag[MW-1:0]) << FB;
		st3_nxt.im.quo = '0;
		st3_nxt.im.neg = dim_neg;
		st3_nxt.im.ovf = 1'b0;

		st3_nxt.tag = as_s2;
		case (kind_s2)
			OP_ADD, OP_SUB: begin
				st3_nxt.tag = as_s2;
			end
			OP_MUL: begin
				st3_nxt.tag.is_div = 1'b0;
				st3_nxt.tag.re = mul_re.val;
				st3_nxt.tag.im = mul_im.val;
				st3_nxt.tag.sat = mul_re.sat | mul_im.sat;
				st3_nxt.tag.dz = 1'b0;
			end
			default: begin
				// A zero divisor gives a zero result with its own flag.
				st3_nxt.tag.is_div = (den_s2 != '0);
				st3_nxt.tag.re = '0;
				st3_nxt.tag.im = '0;
				st3_nxt.tag.sat = 1'b0;
				st3_nxt.tag.dz = (den_s2 == '0);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s3) st3_s3 <= st3_nxt;
	end

	// Divide stages: stage i decides quotient bit QW-1-i for both lanes.
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int J = QW - 1 - i;
		dstg_t src;
		dstg_t nxt;
		logic src_v;
		logic [CW-1:0] dsh;

		if (i == 0) begin : g_first
			assign src = st3_s3;
			assign src_v = v_s3;
		end else begin : g_next
			assign src = dstg_sd[i-1];
			assign src_v = dv_sd[i-1];
		end

		if (i == QW - 1) begin : g_last
			assign en_d[i] = !dv_sd[i] || en_out;
		end else begin : g_mid
			assign en_d[i] = !dv_sd[i] || en_d[i+1];
		end

		always_comb begin
			dsh = CW'(src.den) << J;
			nxt = src;
			nxt.re = div_step(src.re, dsh, QW'(1) << J);
			nxt.im = div_step(src.im, dsh, QW'(1) << J);
			if (i == 0) begin
				nxt.re.ovf = CW'(src.re.rem) >= (CW'(src.den) << QW);
				nxt.im.ovf = CW'(src.im.rem) >= (CW'(src.den) << QW);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_sd[i] <= 1'b0;
			end else if (en_d[i]) begin
				dv_sd[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[i]) dstg_sd[i] <= nxt;
		end
	end

	// Output register: divide results get their sign and clip here.
	always_comb begin
		fin_re = div_fin(dstg_sd[QW-1].re);
		fin_im = div_fin(dstg_sd[QW-1].im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en_out) begin
			v_out_q <= dv_sd[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			if (dstg_sd[QW-1].tag.is_div) begin
				res_re_q <= fin_re.val;
				res_im_q <= fin_im.val;
				sat_q <= fin_re.sat | fin_im.sat;
				dz_q <= 1'b0;
			end else begin
				res_re_q <= dstg_sd[QW-1].tag.re;
				res_im_q <= dstg_sd[QW-1].tag.im;
				sat_q <= dstg_sd[QW-1].tag.sat;
				dz_q <= dstg_sd[QW-1].tag.dz;
			end
		end
	end

	assign rsp.valid = v_out_q;
	assign rsp.res_real = res_re_q;
	assign rsp.res_imag = res_im_q;
	assign rsp.saturated = sat_q;
	assign rsp.divide_by_zero = dz_q;

`ifndef SYNTHESIS
	// A zero divisor always comes out as a clean zero.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_by_zero |->
			rsp.res_real == '0 && rsp.res_imag == '0 && !rsp.saturated)
		else $error("divide by zero result not zero");

	// Stage 3 never marks an item both as a real divide and as divide by zero.
	a_tag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !(st3_s3.tag.is_div && st3_s3.tag.dz))
		else $error("divide tag conflict");

	// A stalled stage 3 keeps its item.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en_d[0] |=> v_s3 && $stable(st3_s3))
		else $error("stage 3 lost its item during a stall");

	// A full last divide stage can only move when the output register moves.
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dv_sd[QW-1] && v_out_q && !rsp.ready |=> dv_sd[QW-1] && v_out_q)
		else $error("divide pipe tail dropped an item");
`endif

endmodule
